// File: src/apn_pkg.sv
// apn_pkg: shared types and constants of the absolute path normalizer
// used by the channel interfaces, apn_front, apn_back and the top level
// no dependencies
package apn_pkg;

    // default sizes, overridable on the top level
    localparam int PATH_LEN_DEF = 4096;
    localparam int MAX_SEG_DEF  = 64;

    // fixed field widths of the channels
    localparam int CHAR_W = 8;
    localparam int RIDX_W = 12;
    localparam int OLEN_W = 12;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;

    // dot count of the segment being received
    localparam logic [1:0] DOTS_NONE = 2'd0;
    localparam logic [1:0] DOTS_ONE  = 2'd1;
    localparam logic [1:0] DOTS_TWO  = 2'd2;

    typedef enum logic {
        OP_CHAR = 1'b0,
        OP_READ = 1'b1
    } apn_op_t;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'b00,
        KIND_SLASH = 2'b01,
        KIND_DOT   = 2'b10
    } apn_kind_t;

    // classified request as it sits in the queue
    typedef struct packed {
        apn_op_t            opcode;
        apn_kind_t          kind;
        logic [CHAR_W-1:0]  char_byte;
        logic               is_last;
        logic [RIDX_W-1:0]  read_index;
    } apn_item_t;

endpackage

// File: src/apn_in_if.sv
// apn_in_if: request channel of the path normalizer, valid/ready handshake
// depends on apn_pkg
interface apn_in_if;
    import apn_pkg::*;

    logic                valid;
    logic                ready;
    logic                opcode;
    logic [CHAR_W-1:0]   char_byte;
    logic                is_last;
    logic [RIDX_W-1:0]   read_index;

    modport source (output valid, output opcode, output char_byte, output is_last,
                    output read_index, input ready);
    modport sink   (input valid, input opcode, input char_byte, input is_last,
                    input read_index, output ready);
endinterface

// File: src/apn_out_if.sv
// apn_out_if: result channel of the path normalizer, valid/ready handshake
// depends on apn_pkg
interface apn_out_if;
    import apn_pkg::*;

    logic                valid;
    logic                ready;
    logic                done_res;
    logic                path_valid;
    logic [OLEN_W-1:0]   out_length;
    logic [CHAR_W-1:0]   read_byte;

    modport source (output valid, output done_res, output path_valid, output out_length,
                    output read_byte, input ready);
    modport sink   (input valid, input done_res, input path_valid, input out_length,
                    input read_byte, output ready);
endinterface

// File: src/absolute_path_normalizer_core.sv
// absolute_path_normalizer_core: top level of the path normalizer
// depends on apn_pkg, apn_in_if, apn_out_if, apn_front and apn_back
//
// usage
//  - path_in carries requests: opcode char sends one path byte (is_last on the
//    final byte of the path), opcode read asks for byte read_index of the result
//  - result returns exactly one item per request, in order: done_res,
//    path_valid and out_length on the last byte of a path, read_byte for reads
//  - the first byte of a path must be a slash; repeated slashes collapse,
//    "." is dropped, ".." pops one kept segment, overflow makes the path invalid
//  - throughput: one request per cycle, sustained while the receiver is ready; a
//    character needs one constant update plus at most one segment stack read, which is prefetched
//  - a request passes one queue stage, then the output register, which is loaded
//    together with the registered store read
//  - a stalled receiver holds the result register; the front queue (two
//    entries) keeps taking requests until it is full, then drops ready
//  - reset clears the path state to a bare root and empties queue and output;
//    store and stack contents are not cleared, there is no clearing pass
module absolute_path_normalizer_core #(
    parameter int PATH_LEN = apn_pkg::PATH_LEN_DEF,
    parameter int MAX_SEG  = apn_pkg::MAX_SEG_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    apn_in_if.sink    path_in,
    apn_out_if.source result
);
    import apn_pkg::*;

    // queue head between the front and back halves
    apn_item_t head;
    logic      head_valid;
    logic      head_take;

    apn_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .path_in    (path_in),
        .head       (head),
        .head_valid (head_valid),
        .head_take  (head_take)
    );

    // back half owns the store, the segment stack and the output register
    apn_back #(
        .PATH_LEN (PATH_LEN),
        .MAX_SEG  (MAX_SEG)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (head),
        .item_valid (head_valid),
        .item_take  (head_take),
        .result     (result)
    );

endmodule

// File: src/apn_front.sv
// apn_front: accepts requests, classifies the character and queues them
// depends on apn_pkg and apn_in_if
module apn_front (
    input  logic               clk,
    input  logic               rst_n,
    apn_in_if.sink             path_in,
    output apn_pkg::apn_item_t head,
    output logic               head_valid,
    input  logic               head_take
);
    import apn_pkg::*;

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [NW-1:0] FULL_CNT = NW'(QUEUE_DEPTH);
    localparam logic [QW-1:0] LAST_PTR = QW'(QUEUE_DEPTH - 1);

    apn_item_t         q_mem [QUEUE_DEPTH];
    logic [QW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]     count_reg, count_next;
    logic              push;
    apn_item_t         new_item;

    always_comb
    begin
        new_item.opcode     = apn_op_t'(path_in.opcode);
        new_item.char_byte  = path_in.char_byte;
        new_item.is_last    = path_in.is_last;
        new_item.read_index = path_in.read_index;
        case (path_in.char_byte)
            CHAR_SLASH: new_item.kind = KIND_SLASH;
            CHAR_DOT:   new_item.kind = KIND_DOT;
            default:    new_item.kind = KIND_OTHER;
        endcase
    end

    assign path_in.ready = (count_reg != FULL_CNT);
    assign push          = path_in.valid && path_in.ready;
    assign head_valid    = (count_reg != '0);
    assign head          = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + QW'(1);
        end
        if (head_take)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + QW'(1);
        end
        if (push && !head_take)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (!push && head_take)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

`ifndef ASSERT_OFF
    // back end never pulls from an empty queue
    a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        head_take |-> head_valid)
        else $error("queue popped while empty");

    // a push without a pop raises the occupancy by one
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !head_take) |=> (count_reg == $past(count_reg) + NW'(1)))
        else $error("queue count lost a push");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count above depth");
`endif

endmodule

// File: src/apn_back.sv
// apn_back: executes queued requests, keeps the normalized path and segment stack
// depends on apn_pkg and apn_out_if
module apn_back #(
    parameter int PATH_LEN = apn_pkg::PATH_LEN_DEF,
    parameter int MAX_SEG  = apn_pkg::MAX_SEG_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  apn_pkg::apn_item_t item,
    input  logic               item_valid,
    output logic               item_take,
    apn_out_if.source          result
);
    import apn_pkg::*;

    localparam int AW = $clog2(PATH_LEN);
    localparam int LW = AW + 1;
    localparam int KW = $clog2(MAX_SEG + 1);
    localparam int SW = $clog2(MAX_SEG);
    localparam int CW = (LW > RIDX_W) ? LW : RIDX_W;
    localparam logic [LW:0]   PATH_LIM = (LW + 1)'(PATH_LEN);
    localparam logic [LW-1:0] PEND_MAX = LW'(PATH_LEN);
    localparam logic [KW-1:0] SEG_LIM  = KW'(MAX_SEG);

    // memories
    logic [CHAR_W-1:0] store_mem [PATH_LEN];
    logic [AW-1:0]     stk_mem   [MAX_SEG];

    // path state
    logic [AW-1:0]     len_reg,   len_next;
    logic [LW-1:0]     base_reg,  base_next;
    logic [KW-1:0]     kept_reg,  kept_next;
    logic [LW-1:0]     pend_reg,  pend_next;
    logic [1:0]        dots_reg,  dots_next;
    logic              first_reg, first_next;
    logic              err_reg,   err_next;
    logic [AW-1:0]     top_reg,   top_next;
    logic [AW-1:0]     below_reg;
    logic              sep_pend_reg, sep_pend_next;
    logic [AW-1:0]     sep_addr_reg, sep_addr_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic              done_reg,  done_next;
    logic              pvalid_reg, pvalid_next;
    logic [OLEN_W-1:0] olen_reg,  olen_next;
    logic              bzero_reg, bzero_next;
    logic              bslash_reg, bslash_next;
    logic [CHAR_W-1:0] rd_data_reg;

    // execute stage
    logic              advance, is_char, is_slash, last;
    logic [AW-1:0]     len_s;
    logic [LW-1:0]     base_s, pend_s, pend_t, seg_len;
    logic [KW-1:0]     kept_s, stk_rd_sum;
    logic [1:0]        dots_s, dots_t, seg_dots;
    logic              err_s, take, end_req, drop, fits;
    logic              do_pop, do_push, set_err, sep_now, sep_set;
    logic [LW:0]       pos, needed;
    logic              char_wr, wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CHAR_W-1:0] wr_data;
    logic [CW-1:0]     idx_ext, len_ext, len_n_ext;
    logic [AW-1:0]     idx_a;

    assign advance   = item_valid && (!out_valid_reg || result.ready);
    assign item_take = advance;
    assign is_char   = (item.opcode == OP_CHAR);
    assign is_slash  = (item.kind == KIND_SLASH);
    assign last      = item.is_last;

    // a new path starts from the bare root
    assign len_s  = first_reg ? AW'(1) : len_reg;
    assign base_s = first_reg ? LW'(1) : base_reg;
    assign kept_s = first_reg ? '0 : kept_reg;
    assign pend_s = first_reg ? '0 : pend_reg;
    assign dots_s = first_reg ? DOTS_NONE : dots_reg;
    assign err_s  = first_reg ? !is_slash : err_reg;

    // ordinary character goes to the pending segment
    assign take    = !err_s && !is_slash;
    assign pos     = {1'b0, base_s} + {1'b0, pend_s};
    assign char_wr = advance && is_char && take && (pos < PATH_LIM);
    assign pend_t  = (pend_s < PEND_MAX) ? pend_s + LW'(1) : pend_s;
    assign dots_t  = ((item.kind == KIND_DOT) && (LW'(dots_s) == pend_s) && (dots_s != DOTS_TWO))
                     ? dots_s + 2'd1 : DOTS_NONE;

    // segment end on a slash, or on the last character
    assign end_req  = !err_s && (is_slash || last);
    assign seg_len  = is_slash ? pend_s : pend_t;
    assign seg_dots = is_slash ? dots_s : dots_t;
    assign needed   = {1'b0, base_s} + {1'b0, seg_len};
    assign drop     = (seg_len == '0) || (seg_dots == DOTS_ONE);
    assign fits     = (kept_s < SEG_LIM) && (needed < PATH_LIM);
    assign do_pop   = end_req && !drop && (seg_dots == DOTS_TWO) && (kept_s != '0);
    assign do_push  = end_req && !drop && (seg_dots != DOTS_TWO) && fits;
    assign set_err  = end_req && !drop && (seg_dots != DOTS_TWO) && !fits;

    // separator before a kept segment; deferred when the port is busy with a char
    assign sep_now = advance && is_char && do_push && (len_s > AW'(1)) && is_slash;
    assign sep_set = advance && is_char && do_push && (len_s > AW'(1)) && !is_slash;

    always_comb
    begin
        len_next   = len_reg;
        base_next  = base_reg;
        kept_next  = kept_reg;
        pend_next  = pend_reg;
        dots_next  = dots_reg;
        first_next = first_reg;
        err_next   = err_reg;
        top_next   = top_reg;
        if (advance && is_char)
        begin
            err_next   = err_s || set_err;
            first_next = last;
            len_next   = len_s;
            base_next  = base_s;
            kept_next  = kept_s;
            top_next   = top_reg;
            if (do_pop)
            begin
                len_next  = (top_reg > AW'(1)) ? top_reg - AW'(1) : top_reg;
                base_next = LW'(top_reg);
                kept_next = kept_s - KW'(1);
                top_next  = below_reg;
            end
            else if (do_push)
            begin
                len_next  = needed[AW-1:0];
                base_next = needed[LW-1:0] + LW'(1);
                kept_next = kept_s + KW'(1);
                top_next  = base_s[AW-1:0];
            end
            if (last || is_slash && !err_s)
            begin
                pend_next = '0;
                dots_next = DOTS_NONE;
            end
            else if (err_s)
            begin
                pend_next = pend_s;
                dots_next = dots_s;
            end
            else
            begin
                pend_next = pend_t;
                dots_next = dots_t;
            end
        end
    end

    assign stk_rd_sum = kept_next - KW'(2);

    // single write port of the output store
    always_comb
    begin
        wr_en         = 1'b0;
        wr_addr       = pos[AW-1:0];
        wr_data       = item.char_byte;
        sep_pend_next = sep_pend_reg;
        sep_addr_next = sep_addr_reg;
        if (char_wr)
        begin
            wr_en = 1'b1;
        end
        else if (sep_now)
        begin
            wr_en   = 1'b1;
            wr_addr = len_s;
            wr_data = CHAR_SLASH;
        end
        else if (sep_pend_reg)
        begin
            wr_en         = 1'b1;
            wr_addr       = sep_addr_reg;
            wr_data       = CHAR_SLASH;
            sep_pend_next = 1'b0;
        end
        if (sep_set)
        begin
            sep_pend_next = 1'b1;
            sep_addr_next = len_s;
        end
    end

    // result fields
    assign idx_ext   = CW'(item.read_index);
    assign idx_a     = idx_ext[AW-1:0];
    assign len_ext   = CW'(len_reg);
    assign len_n_ext = CW'(len_next);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        done_next      = done_reg;
        pvalid_next    = pvalid_reg;
        olen_next      = olen_reg;
        bzero_next     = bzero_reg;
        bslash_next    = bslash_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            done_next      = is_char && last;
            pvalid_next    = is_char && last && !err_next;
            olen_next      = (is_char && last && !err_next) ? len_n_ext[OLEN_W-1:0] : '0;
            bzero_next     = is_char || err_reg || (idx_ext >= len_ext);
            bslash_next    = (idx_ext == '0) || (sep_pend_reg && (sep_addr_reg == idx_a));
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= AW'(1);
            base_reg      <= LW'(1);
            kept_reg      <= '0;
            pend_reg      <= '0;
            dots_reg      <= DOTS_NONE;
            first_reg     <= 1'b1;
            err_reg       <= 1'b0;
            sep_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            base_reg      <= base_next;
            kept_reg      <= kept_next;
            pend_reg      <= pend_next;
            dots_reg      <= dots_next;
            first_reg     <= first_next;
            err_reg       <= err_next;
            sep_pend_reg  <= sep_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        sep_addr_reg <= sep_addr_next;
        done_reg     <= done_next;
        pvalid_reg   <= pvalid_next;
        olen_reg     <= olen_next;
        bzero_reg    <= bzero_next;
        bslash_reg   <= bslash_next;
    end

    // output store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (advance && !is_char)
        begin
            rd_data_reg <= store_mem[idx_a];
        end
    end

    // segment stack: push write, registered read of the entry below the top
    always_ff @(posedge clk)
    begin
        if (advance && is_char && do_push)
        begin
            stk_mem[kept_s[SW-1:0]] <= base_s[AW-1:0];
        end
        if (advance && is_char)
        begin
            below_reg <= stk_mem[stk_rd_sum[SW-1:0]];
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.done_res   = done_reg;
    assign result.path_valid = pvalid_reg;
    assign result.out_length = olen_reg;
    assign result.read_byte  = bzero_reg ? '0 : (bslash_reg ? CHAR_SLASH : rd_data_reg);

`ifndef ASSERT_OFF
    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= SEG_LIM)
        else $error("kept segment count above limit");

    // next segment base always tracks the kept length
    a_base_track: assert property (@(posedge clk) disable iff (!rst_n)
        base_reg == LW'(len_reg) + LW'(len_reg > AW'(1)))
        else $error("segment base out of step with length");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg != '0)
        else $error("normalized length dropped to zero");

    // a deferred separator is always drained before another is queued
    a_sep_single: assert property (@(posedge clk) disable iff (!rst_n)
        sep_set |-> !sep_pend_reg)
        else $error("deferred separator overwritten");
`endif

endmodule

// File: test/apn_result_check.sv
`timescale 1ns / 1ps
// apn_result_check: watches both channels of the path normalizer, predicts each result
// and compares it field by field; depends on apn_pkg, apn_in_if and apn_out_if
module apn_result_check #(
    parameter int PATH_LEN = apn_pkg::PATH_LEN_DEF,
    parameter int MAX_SEG  = apn_pkg::MAX_SEG_DEF
) (
    input  logic clk,
    input  logic rst_n,
    apn_in_if    path_in,
    apn_out_if   result,
    output int   errors,
    output int   outstanding
);
    import apn_pkg::*;

    typedef struct packed {
        logic              done_res;
        logic              path_valid;
        logic [OLEN_W-1:0] out_length;
        logic [CHAR_W-1:0] read_byte;
    } norm_result_t;

    // predicted normalizer state
    logic [CHAR_W-1:0] text_store [PATH_LEN];
    int unsigned       seg_start [MAX_SEG];
    int unsigned       seg_count;
    int unsigned       text_len;
    int unsigned       pend_len;
    int unsigned       pend_dots;
    bit                path_fresh;
    bit                path_bad;

    norm_result_t      expected_q [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    function automatic void clear_paths();
        foreach (text_store[i])
            text_store[i] = '0;
        foreach (seg_start[i])
            seg_start[i] = 0;
        text_store[0] = CHAR_SLASH;
        seg_count     = 0;
        text_len      = 1;
        pend_len      = 0;
        pend_dots     = DOTS_NONE;
        path_fresh    = 1'b1;
        path_bad      = 1'b0;
    endfunction

    // first free position for a new segment, past the separator if not at root
    function automatic int unsigned next_base();
        return text_len + ((text_len > 1) ? 1 : 0);
    endfunction

    function automatic void close_segment();
        int unsigned len;
        int unsigned dots;
        int unsigned back;
        int unsigned base;
        int unsigned needed;
        len       = pend_len;
        dots      = pend_dots;
        pend_len  = 0;
        pend_dots = DOTS_NONE;
        if (len == 0 || dots == DOTS_ONE)
            return;
        if (dots == DOTS_TWO)
        begin
            // pop one kept segment, nothing to do at the root
            if (seg_count != 0)
            begin
                back = seg_start[seg_count - 1];
                if (back > 1)
                    back--;
                text_len = back;
                seg_count--;
            end
            return;
        end
        if (seg_count >= MAX_SEG)
        begin
            path_bad = 1'b1;
            return;
        end
        base   = next_base();
        needed = base + len;
        if (needed >= PATH_LEN)
        begin
            path_bad = 1'b1;
            return;
        end
        if (text_len > 1)
            text_store[text_len] = CHAR_SLASH;
        seg_start[seg_count] = base;
        seg_count++;
        text_len = needed;
    endfunction

    function automatic void absorb_char(input logic [CHAR_W-1:0] c);
        int unsigned pos;
        if (c == CHAR_SLASH)
        begin
            close_segment();
            return;
        end
        // pending bytes land past the kept text
        pos = next_base() + pend_len;
        if (pos < PATH_LEN)
            text_store[pos] = c;
        if (c == CHAR_DOT && pend_dots == pend_len && pend_dots < DOTS_TWO)
            pend_dots++;
        else
            pend_dots = DOTS_NONE;
        if (pend_len < PATH_LEN)
            pend_len++;
    endfunction

    function automatic norm_result_t normalize_step(input apn_op_t op,
                                                   input logic [CHAR_W-1:0] c,
                                                   input logic last,
                                                   input logic [RIDX_W-1:0] idx);
        norm_result_t r;
        r = '0;
        if (op == OP_READ)
        begin
            if (!path_bad && idx < text_len && idx < PATH_LEN)
                r.read_byte = text_store[idx];
            return r;
        end
        if (path_fresh)
        begin
            path_fresh    = 1'b0;
            text_store[0] = CHAR_SLASH;
            text_len      = 1;
            seg_count     = 0;
            pend_len      = 0;
            pend_dots     = DOTS_NONE;
            path_bad      = (c != CHAR_SLASH);
        end
        if (!path_bad)
            absorb_char(c);
        if (last)
        begin
            if (!path_bad)
                close_segment();
            path_fresh   = 1'b1;
            pend_len     = 0;
            pend_dots    = DOTS_NONE;
            r.done_res   = 1'b1;
            r.path_valid = !path_bad;
            r.out_length = path_bad ? '0 : OLEN_W'(text_len);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        norm_result_t want;
        if (!rst_n)
        begin
            clear_paths();
            expected_q.delete();
            errors = 0;
            outstanding <= 0;
        end
        else
        begin
            if (path_in.valid && path_in.ready)
                expected_q = {expected_q, normalize_step(apn_op_t'(path_in.opcode),
                                                         path_in.char_byte,
                                                         path_in.is_last,
                                                         path_in.read_index)};
            if (result.valid && result.ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch(
                        $sformatf("result with nothing pending: done=%0b valid=%0b",
                                  result.done_res, result.path_valid));
                else
                begin
                    want = expected_q.pop_front();
                    if (result.done_res !== want.done_res)
                        report_mismatch($sformatf("done_res %0b, want %0b",
                                                  result.done_res, want.done_res));
                    if (result.path_valid !== want.path_valid)
                        report_mismatch($sformatf("path_valid %0b, want %0b",
                                                  result.path_valid, want.path_valid));
                    if (result.out_length !== want.out_length)
                        report_mismatch($sformatf("out_length %0d, want %0d",
                                                  result.out_length, want.out_length));
                    if (result.read_byte !== want.read_byte)
                        report_mismatch($sformatf("read_byte %02h, want %02h",
                                                  result.read_byte, want.read_byte));
                end
            end
            outstanding <= expected_q.size();
        end
    end

endmodule

// File: test/absolute_path_normalizer_core_test.sv
`timescale 1ns / 1ps
// absolute_path_normalizer_core_test: drives paths and reads into the normalizer and gives
// the verdict; depends on apn_pkg, apn_in_if, apn_out_if, apn_result_check and the core
module absolute_path_normalizer_core_test;
    import apn_pkg::*;

    localparam int ITEM_TARGET = 1150;
    localparam int BIG_COUNT   = 2;
    // about 1200 requests; even with idling on both sides the run stays far below this
    localparam int CYCLE_LIMIT = 50_000;
    // time from request to result, plus margin
    localparam int SETTLE      = 8;

    logic clk = 1'b0;
    logic rst_n;
    bit   no_gaps;
    int   cycle_count = 0;
    int   sent_items  = 0;
    int   big_next    = 0;
    int   errors;
    int   outstanding;

    // bytes of the path being built for sending
    logic [CHAR_W-1:0] path_buf [$];

    apn_in_if  path_in ();
    apn_out_if result ();

    absolute_path_normalizer_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .path_in (path_in),
        .result  (result)
    );

    apn_result_check result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .path_in     (path_in),
        .result      (result),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls with a probability of about one in ten, never during the steady stretch
    always @(posedge clk)
        result.ready <= no_gaps || ($urandom_range(0, 99) >= 10);

    // hard stop in case the core hangs or loses a result
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("absolute_path_normalizer_core_test: errors");
            $finish;
        end
    end

    // one request: optional idle cycles, then hold it until accepted
    task automatic put_req(input apn_op_t op, input logic [CHAR_W-1:0] c, input logic last,
                           input logic [RIDX_W-1:0] idx);
        while (!no_gaps && $urandom_range(0, 99) < 10)
        begin
            path_in.valid <= 1'b0;
            @(posedge clk);
        end
        path_in.valid      <= 1'b1;
        path_in.opcode     <= op;
        path_in.char_byte  <= c;
        path_in.is_last    <= last;
        path_in.read_index <= idx;
        @(posedge clk);
        while (!path_in.ready)
            @(posedge clk);
        sent_items++;
    endtask

    // unused fields get random values so they are seen to be ignored
    task automatic put_char(input logic [CHAR_W-1:0] c, input logic last);
        put_req(OP_CHAR, c, last, RIDX_W'($urandom_range(0, 4095)));
    endtask

    task automatic put_read(input logic [RIDX_W-1:0] idx);
        put_req(OP_READ, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), idx);
    endtask

    // stop sending until every request has its result back
    task automatic drain();
        path_in.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // mostly near the current length so reads hit kept text, sometimes anywhere
    function automatic logic [RIDX_W-1:0] pick_index(input int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return RIDX_W'($urandom_range(0, (span > 4095) ? 4095 : span));
        if (r < 90)
            return RIDX_W'($urandom_range(0, 80));
        return RIDX_W'($urandom_range(0, 4095));
    endfunction

    // any byte but a slash, dots often
    function automatic logic [CHAR_W-1:0] name_byte();
        logic [CHAR_W-1:0] c;
        if ($urandom_range(0, 99) < 15)
            return CHAR_DOT;
        c = CHAR_W'($urandom_range(0, 255));
        if (c == CHAR_SLASH)
            c = ~c;
        return c;
    endfunction

    function automatic void add_name(input int len);
        repeat (len)
            path_buf = {path_buf, name_byte()};
    endfunction

    function automatic void add_run(input logic [CHAR_W-1:0] c, input int n);
        repeat (n)
            path_buf = {path_buf, c};
    endfunction

    // well formed path with dot segments, empty segments and repeated slashes
    function automatic void build_random_path();
        int nseg;
        int kind;
        path_buf.delete();
        add_run(CHAR_SLASH, ($urandom_range(0, 3) == 0) ? 2 : 1);
        nseg = $urandom_range(0, 7);
        for (int s = 0; s < nseg; s++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 15)
                add_run(CHAR_DOT, 1);
            else if (kind < 32)
                add_run(CHAR_DOT, 2);
            else if (kind < 37)
                add_run(CHAR_DOT, 3);
            else if (kind >= 42)
                add_name($urandom_range(1, 6));
            // the last segment ends the path without a slash most of the time
            if (s != nseg - 1 || $urandom_range(0, 2) == 0)
                add_run(CHAR_SLASH, ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1);
        end
    endfunction

    // many segments, to reach the segment limit; plain names are fixed letters
    function automatic void build_deep_path(input int nseg, input int len, input int pop_pct,
                                            input bit plain);
        path_buf.delete();
        path_buf = {path_buf, CHAR_SLASH};
        for (int s = 0; s < nseg; s++)
        begin
            if ($urandom_range(0, 99) < pop_pct)
                add_run(CHAR_DOT, 2);
            else if (plain)
                add_run(CHAR_W'(8'h61 + s % 26), len);
            else
                add_name(len);
            if (s != nseg - 1)
                path_buf = {path_buf, CHAR_SLASH};
        end
    endfunction

    // random bytes, slashes and dots frequent, often not absolute
    function automatic void build_noise();
        int r;
        path_buf.delete();
        if ($urandom_range(0, 1) == 1)
            path_buf = {path_buf, CHAR_SLASH};
        repeat ($urandom_range(1, 12))
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                path_buf = {path_buf, CHAR_SLASH};
            else if (r < 45)
                path_buf = {path_buf, CHAR_DOT};
            else
                path_buf = {path_buf, CHAR_W'($urandom_range(0, 255))};
        end
    endfunction

    // the path in path_buf with reads mixed in, the last byte flagged
    task automatic send_path(input int read_pct, input int tail);
        for (int i = 0; i < path_buf.size(); i++)
        begin
            put_char(path_buf[i], i == path_buf.size() - 1);
            if ($urandom_range(0, 99) < read_pct)
                put_read(pick_index(i + 2));
        end
        repeat (tail)
            put_read(pick_index(path_buf.size() + 1));
    endtask

    // deep paths right at the segment limit and one segment past it
    task automatic send_big();
        path_buf.delete();
        case (big_next)
            0:       build_deep_path(MAX_SEG_DEF, 1, 0, 1'b1);
            default: build_deep_path(MAX_SEG_DEF + 1, 1, 0, 1'b1);
        endcase
        send_path(1, 3);
        put_read(RIDX_W'(PATH_LEN_DEF - 2));
        put_read(RIDX_W'(PATH_LEN_DEF - 1));
        big_next++;
    endtask

    initial
    begin : stimulus
        int seq;
        int kind;
        rst_n              = 1'b0;
        no_gaps            = 1'b0;
        path_in.valid      = 1'b0;
        path_in.opcode     = OP_CHAR;
        path_in.char_byte  = '0;
        path_in.is_last    = 1'b0;
        path_in.read_index = '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: read past the bare root before any path
        put_read(RIDX_W'(4095));
        // path of a single slash, then read it back and just past it
        put_char(CHAR_SLASH, 1'b1);
        put_read(RIDX_W'(0));
        put_read(RIDX_W'(1));
        // single byte that is not a slash: invalid, reads blocked while in error
        put_char(8'h61, 1'b1);
        put_read(RIDX_W'(0));
        // not absolute, the rest of the path is ignored up to the last byte
        put_char(8'h78, 1'b0);
        put_char(CHAR_SLASH, 1'b0);
        put_char(8'h62, 1'b1);
        // "//../\xff/./../..~/": repeated slash, dot dot at root, pending byte
        // hidden, dot dropped, pop, then a kept segment that only starts with dots
        put_char(CHAR_SLASH, 1'b0);
        put_char(CHAR_SLASH, 1'b0);
        put_char(CHAR_DOT, 1'b0);
        put_char(CHAR_DOT, 1'b0);
        put_char(CHAR_SLASH, 1'b0);
        put_char(8'hFF, 1'b0);
        put_read(RIDX_W'(1));
        put_char(CHAR_SLASH, 1'b0);
        put_read(RIDX_W'(1));
        put_char(CHAR_DOT, 1'b0);
        put_char(CHAR_SLASH, 1'b0);
        put_char(CHAR_DOT, 1'b0);
        put_char(CHAR_DOT, 1'b0);
        put_char(CHAR_SLASH, 1'b0);
        put_char(CHAR_DOT, 1'b0);
        put_char(CHAR_DOT, 1'b0);
        put_char(8'h7E, 1'b0);
        put_char(CHAR_SLASH, 1'b1);
        put_read(RIDX_W'(3));

        // hold the sender back until the core is empty
        drain();

        // random part: mostly well formed paths with reads mixed in
        seq = 0;
        while (sent_items < ITEM_TARGET)
        begin
            // a stretch with no idling on either side
            no_gaps <= (sent_items >= 400 && sent_items < 650);
            seq++;
            if (seq % 15 == 7 && big_next < BIG_COUNT)
                send_big();
            else
            begin
                kind = $urandom_range(0, 99);
                if (kind < 65)
                begin
                    build_random_path();
                    send_path(15, $urandom_range(0, 3));
                end
                else if (kind < 68)
                begin
                    build_deep_path($urandom_range(58, 70), 1, 10, 1'b0);
                    send_path(3, 2);
                end
                else if (kind < 85)
                begin
                    build_noise();
                    send_path(10, $urandom_range(0, 2));
                end
                else
                    repeat ($urandom_range(1, 4))
                        put_read(pick_index(16));
            end
            if (seq == 30)
                drain();
        end
        while (big_next < BIG_COUNT)
            send_big();

        // wait for the last results, then wait out the SETTLE margin for strays
        drain();
        repeat (SETTLE)
            @(posedge clk);
        if (errors == 0)
            $display("absolute_path_normalizer_core_test: clean");
        else
            $display("absolute_path_normalizer_core_test: errors");
        $finish;
    end

endmodule

// File: files.f
src/apn_pkg.sv
src/apn_in_if.sv
src/apn_out_if.sv
src/apn_front.sv
src/apn_back.sv
src/absolute_path_normalizer_core.sv
test/apn_result_check.sv
test/absolute_path_normalizer_core_test.sv
